// ----- rtl/ipte_pkg.sv -----
`default_nettype none

package ipte_pkg;

  // character codes
  localparam logic [7:0] DotChar   = 8'h2E;
  localparam logic [7:0] ColonChar = 8'h3A;
  localparam logic [7:0] DigitZero = 8'h30;
  localparam logic [7:0] DigitNine = 8'h39;

  // length of the current digit run, saturating just above the port limit
  typedef logic [2:0] run_len_t;
  localparam run_len_t OctetDigits = 3'd3;
  localparam run_len_t PortDigits  = 3'd5;
  localparam run_len_t RunLenSat   = 3'd6;

  // number of dot-terminated groups directly in front of the current run
  typedef logic [1:0] chain_t;
  localparam int unsigned OctetCount = 4;
  localparam chain_t ChainFull = chain_t'(OctetCount - 1);

  typedef logic [3:0] digit_t;
  typedef logic [7:0] octet_t;

  // value of the last three digits, mod 256
  function automatic octet_t octet_value(digit_t d2, digit_t d1, digit_t d0);
    logic [9:0] sum;
    sum = 10'(d2) * 10'd100 + 10'(d1) * 10'd10 + 10'(d0);
    return sum[7:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/ipv4_port_text_extractor.sv -----
// ipv4_port_text_extractor
// Scans text one byte per transaction on the input channel (text_byte_i,
// end_of_text_i, in_valid_i/in_ready_o) and reports each non-overlapping
// leftmost-first "d.d.d.d:p" on the output channel (ipv4_address_o, port_o,
// out_valid_o/out_ready_i). A match is reported with the first non-digit
// after the port, or with the last port digit when end_of_text_i marks it.
// That terminating byte is consumed; scanning restarts after it. The end of
// text always clears the scan state.
// Throughput is one byte per cycle while in_ready_o is high: each byte only
// updates a digit run tracker and a few small registers. A result is
// registered from its input transaction into the output register.
// When the receiver stalls, one further result is held in a skid register;
// in_ready_o drops only while that skid register is occupied.
// Reset clears the scan state and both output slots; payload registers are
// not reset.
`default_nettype none

module ipv4_port_text_extractor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      ipv4_address_o,
  output logic [15:0]      port_o
);
  import ipte_pkg::*;

  // scan state
  run_len_t   run_len_q, run_len_d;
  chain_t     chain_q, chain_d;
  logic       armed_q, armed_d;
  digit_t     dig_q [3];
  digit_t     dig_d [3];
  octet_t     oct_q [3];
  octet_t     oct_d [3];
  logic [31:0] addr_q, addr_d;
  logic [15:0] port_acc_q, port_acc_d;

  // output register and skid register
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_addr_q, out_addr_d;
  logic [15:0] out_port_q, out_port_d;
  logic        skid_valid_q, skid_valid_d;
  logic [31:0] skid_addr_q, skid_addr_d;
  logic [15:0] skid_port_q, skid_port_d;

  logic        in_fire;
  logic        out_fire;
  logic        is_digit;
  digit_t      digit;
  run_len_t    run_len_inc;
  logic [15:0] port_next;
  octet_t      cur_octet;
  logic        found;
  logic [15:0] found_port;

  assign in_ready_o     = ~skid_valid_q;
  assign in_fire        = in_valid_i & in_ready_o;
  assign out_fire       = out_valid_q & out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign ipv4_address_o = out_addr_q;
  assign port_o         = out_port_q;

  // digit decode and run accumulators
  assign is_digit    = text_byte_i inside {[DigitZero:DigitNine]};
  assign digit       = digit_t'(text_byte_i - DigitZero);
  assign run_len_inc = (run_len_q == RunLenSat) ? RunLenSat : run_len_q + 3'd1;
  assign port_next   = ((run_len_q == '0) ? 16'd0 : ((port_acc_q << 3) + (port_acc_q << 1)))
                       + 16'(digit);
  assign cur_octet   = octet_value(dig_q[2], dig_q[1], dig_q[0]);

  // per-byte scan update
  always_comb begin
    run_len_d  = run_len_q;
    chain_d    = chain_q;
    armed_d    = armed_q;
    dig_d      = dig_q;
    oct_d      = oct_q;
    addr_d     = addr_q;
    port_acc_d = port_acc_q;
    found      = 1'b0;
    found_port = port_acc_q;
    if (in_fire) begin
      if (is_digit) begin
        run_len_d  = run_len_inc;
        port_acc_d = port_next;
        if (run_len_q == '0) begin
          dig_d[2] = '0;
          dig_d[1] = '0;
        end else begin
          dig_d[2] = dig_q[1];
          dig_d[1] = dig_q[0];
        end
        dig_d[0] = digit;
        // final digit of the text may close the port
        found      = end_of_text_i && armed_q && (run_len_inc <= PortDigits);
        found_port = port_next;
      end else begin
        found     = armed_q && (run_len_q != '0) && (run_len_q <= PortDigits);
        run_len_d = '0;
        armed_d   = 1'b0;
        chain_d   = '0;
        case (text_byte_i)
          DotChar: begin
            if (run_len_q != '0) begin
              oct_d[0] = oct_q[1];
              oct_d[1] = oct_q[2];
              oct_d[2] = cur_octet;
              if (run_len_q <= OctetDigits) begin
                chain_d = (chain_q == ChainFull) ? ChainFull : chain_q + 2'd1;
              end else begin
                // a long run can only serve as the first octet
                chain_d = 2'd1;
              end
            end
          end
          ColonChar: begin
            if (chain_q == ChainFull && run_len_q != '0 && run_len_q <= OctetDigits) begin
              armed_d = 1'b1;
              addr_d  = {oct_q[0], oct_q[1], oct_q[2], cur_octet};
            end
          end
          default: begin
          end
        endcase
      end
      // a match or the end of text restarts the scan
      if (found || end_of_text_i) begin
        run_len_d = '0;
        chain_d   = '0;
        armed_d   = 1'b0;
      end
    end
  end

  // output slot and skid slot steering
  always_comb begin
    out_valid_d  = out_valid_q;
    out_addr_d   = out_addr_q;
    out_port_d   = out_port_q;
    skid_valid_d = skid_valid_q;
    skid_addr_d  = skid_addr_q;
    skid_port_d  = skid_port_q;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    if (skid_valid_q) begin
      if (out_fire) begin
        out_valid_d  = 1'b1;
        out_addr_d   = skid_addr_q;
        out_port_d   = skid_port_q;
        skid_valid_d = 1'b0;
      end
    end else if (found) begin
      if (!out_valid_q || out_fire) begin
        out_valid_d = 1'b1;
        out_addr_d  = addr_q;
        out_port_d  = found_port;
      end else begin
        skid_valid_d = 1'b1;
        skid_addr_d  = addr_q;
        skid_port_d  = found_port;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q    <= '0;
      chain_q      <= '0;
      armed_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      run_len_q    <= run_len_d;
      chain_q      <= chain_d;
      armed_q      <= armed_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dig_q       <= dig_d;
    oct_q       <= oct_d;
    addr_q      <= addr_d;
    port_acc_q  <= port_acc_d;
    out_addr_q  <= out_addr_d;
    out_port_q  <= out_port_d;
    skid_addr_q <= skid_addr_d;
    skid_port_q <= skid_port_d;
  end

endmodule

`default_nettype wire

// ----- rtl/ipte_checker.sv -----
`default_nettype none

module ipte_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] ipv4_address_o,
  input wire logic [15:0] port_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(ipv4_address_o) && $stable(port_o))
    else $error("result payload changed while stalled");

  // a new result only follows an input transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("result without input transaction");

  // backpressure only while a result is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind ipv4_port_text_extractor ipte_checker u_ipte_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .ipv4_address_o (ipv4_address_o),
  .port_o         (port_o)
);

`default_nettype wire
